// ===== design/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

    // Sector codes: integer part of hue * 6
    localparam logic [2:0] SECT_RED_YEL = 3'd0;
    localparam logic [2:0] SECT_YEL_GRN = 3'd1;
    localparam logic [2:0] SECT_GRN_CYN = 3'd2;
    localparam logic [2:0] SECT_CYN_BLU = 3'd3;
    localparam logic [2:0] SECT_BLU_MAG = 3'd4;

    // Stage enables handed to the level pipeline
    typedef struct packed {
        logic s2;
        logic s3;
    } t_pipe_en;

    // ceil(y / 255) for y <= 65025, by reciprocal: floor(z/255) = (z + z>>8 + 1) >> 8
    function automatic logic [7:0] ceil_div255(input logic [16:0] y);
        logic [16:0] z;
        logic [16:0] acc;
        z   = y + 17'd254;
        acc = z + {8'd0, z[16:8]} + 17'd1;
        return acc[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== design/hsvrgb_level.sv =====
`default_nettype none

// Two-stage pipeline for one hue-dependent level: ceil(v*s*frac / (255 * 2^HUE_BITS)).
module hsvrgb_level #(
    parameter int HUE_BITS = 16
) (
    input  wire                    i_clk,
    input  hsvrgb_pkg::t_pipe_en   i_en,
    input  wire  [15:0]            i_vs,
    input  wire  [HUE_BITS:0]      i_frac,
    output logic [7:0]             o_cdiv
);
    import hsvrgb_pkg::*;

    localparam int PROD_W = HUE_BITS + 17;

    logic [PROD_W-1:0] r_prod;
    logic [16:0]       n_num;
    logic [7:0]        r_cdiv;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod <= PROD_W'(i_vs) * PROD_W'(i_frac);
        end
    end

    // Integer part plus one when any fraction bit is set, so the ceiling survives the shift
    always_comb begin
        n_num = {1'b0, r_prod[HUE_BITS+15:HUE_BITS]} + 17'(|r_prod[HUE_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_cdiv <= ceil_div255(n_num);
        end
    end

    assign o_cdiv = r_cdiv;

endmodule

`default_nettype wire

// ===== design/hsv_to_rgb_converter.sv =====
`default_nettype none

// Channel   | Direction | Word contents (lowest bit first)
// ----------+-----------+--------------------------------------------------
// s_axis    | in        | hue[HUE_BITS-1:0], saturation[7:0], brightness_value[7:0]
// m_axis    | out       | red[7:0], green[7:0], blue[7:0]
//
// Four register stages; a word can enter every cycle while the output is not stalled.
// The stages carry the chain hue*6 / v*s, the 16 x HUE_BITS+1 products, the
// divide-by-255 ceiling and the final subtract-and-select.
// Reset (synchronous, active low) clears the stage valid bits only.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse under a stall and no word is dropped or repeated.
module hsv_to_rgb_converter #(
    parameter int HUE_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // hue, saturation, brightness_value
    input  wire  [((HUE_BITS+23)/8)*8-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // red, green, blue
    output logic [23:0]                          m_axis_tdata
);
    import hsvrgb_pkg::*;

    localparam int H6_W = HUE_BITS + 3;

    // Input unpacking
    logic [HUE_BITS-1:0] hue;
    logic [7:0]          sat;
    logic [7:0]          val;
    logic [H6_W-1:0]     h6;

    assign hue = s_axis_tdata[HUE_BITS-1:0];
    assign sat = s_axis_tdata[HUE_BITS+7:HUE_BITS];
    assign val = s_axis_tdata[HUE_BITS+15:HUE_BITS+8];
    // hue * 6 as two shifted adds
    assign h6  = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    // Stage enables: advance when empty or when downstream advances
    logic en1, en2, en3, en4;
    t_pipe_en lvl_en;

    logic r1_valid, r2_valid, r3_valid, r4_valid;

    assign en4 = !r4_valid || m_axis_tready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign s_axis_tready = en1;
    assign lvl_en = '{s2: en2, s3: en3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= s_axis_tvalid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    // Stage 1: split hue into sector and fraction, form v*s
    logic [2:0]          r1_sector;
    logic [HUE_BITS-1:0] r1_frac;
    logic [HUE_BITS:0]   r1_cofrac;
    logic [7:0]          r1_val;
    logic                r1_grey;
    logic [15:0]         r1_vs;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_sector <= h6[H6_W-1:HUE_BITS];
            r1_frac   <= h6[HUE_BITS-1:0];
            r1_cofrac <= {1'b1, {HUE_BITS{1'b0}}} - {1'b0, h6[HUE_BITS-1:0]};
            r1_val    <= val;
            r1_grey   <= (sat == 8'd0);
            r1_vs     <= 16'(val) * 16'(sat);
        end
    end

    // Stages 2-3 for q (fraction f) and t (fraction 1-f)
    logic [7:0] q_cdiv;
    logic [7:0] t_cdiv;

    hsvrgb_level #(.HUE_BITS(HUE_BITS)) u_level_q (
        .i_clk  (i_clk),
        .i_en   (lvl_en),
        .i_vs   (r1_vs),
        .i_frac ({1'b0, r1_frac}),
        .o_cdiv (q_cdiv)
    );

    hsvrgb_level #(.HUE_BITS(HUE_BITS)) u_level_t (
        .i_clk  (i_clk),
        .i_en   (lvl_en),
        .i_vs   (r1_vs),
        .i_frac (r1_cofrac),
        .o_cdiv (t_cdiv)
    );

    // Stage 2: ceiling of v*s/255 for p, carry sideband
    logic [2:0] r2_sector;
    logic [7:0] r2_val;
    logic       r2_grey;
    logic [7:0] r2_pc;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sector <= r1_sector;
            r2_val    <= r1_val;
            r2_grey   <= r1_grey;
            r2_pc     <= ceil_div255({1'b0, r1_vs});
        end
    end

    // Stage 3: p = v - ceil(v*s/255)
    logic [2:0] r3_sector;
    logic [7:0] r3_val;
    logic       r3_grey;
    logic [7:0] r3_p;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_sector <= r2_sector;
            r3_val    <= r2_val;
            r3_grey   <= r2_grey;
            r3_p      <= r2_val - r2_pc;
        end
    end

    // Stage 4: finish q and t, order channels by sector
    logic [7:0] lvl_q, lvl_t;
    logic [7:0] n_red, n_green, n_blue;
    logic [23:0] r_out;

    assign lvl_q = r3_val - q_cdiv;
    assign lvl_t = r3_val - t_cdiv;

    always_comb begin
        case (r3_sector)
            SECT_RED_YEL: begin n_red = r3_val; n_green = lvl_t;  n_blue = r3_p;   end
            SECT_YEL_GRN: begin n_red = lvl_q;  n_green = r3_val; n_blue = r3_p;   end
            SECT_GRN_CYN: begin n_red = r3_p;   n_green = r3_val; n_blue = lvl_t;  end
            SECT_CYN_BLU: begin n_red = r3_p;   n_green = lvl_q;  n_blue = r3_val; end
            SECT_BLU_MAG: begin n_red = lvl_t;  n_green = r3_p;   n_blue = r3_val; end
            // magenta to red
            default:      begin n_red = r3_val; n_green = r3_p;   n_blue = lvl_q;  end
        endcase
        // Zero saturation: grey at the value level
        if (r3_grey) begin
            n_red   = r3_val;
            n_green = r3_val;
            n_blue  = r3_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out <= {n_blue, n_green, n_red};
        end
    end

    assign m_axis_tvalid = r4_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ===== design/hsvrgb_checker.sv =====
`default_nettype none

module hsvrgb_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);

    // Words inside the block: accepted in, not yet taken out
    logic [2:0] r_inflight;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 3'd0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    // Stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // No word out without one in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 3'd0)
        else $error("output word without matching input");

    // Four stages hold at most four words
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more words in flight than stages");

    // Input backpressure only when the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // Pipeline comes out of reset empty
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
    import hsvrgb_pkg::*;

    localparam int HUE_BITS     = 16;
    localparam int IN_W         = ((HUE_BITS + 23) / 8) * 8;
    localparam int RANDOM_WORDS = 1525;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 16;

    // One pixel in flight: the input fields and the color it must become
    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [7:0]          sat;
        logic [7:0]          val;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
    } t_rgb_pending;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    wire               s_axis_tready;
    // hue[15:0], saturation[23:16], brightness_value[31:24]
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    wire               m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16]
    wire  [23:0]       m_axis_tdata;

    t_rgb_pending      rgb_pending_q[$];
    int unsigned       fail_count  = 0;
    bit                src_steady  = 1'b0;
    bit                sink_steady = 1'b0;

    hsv_to_rgb_converter #(
        .HUE_BITS(HUE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // floor(v * (255*one - s*frac) / (255*one)); frac == one gives p
    function automatic logic [7:0] scaled_level(input longint unsigned v,
                                                input longint unsigned s,
                                                input longint unsigned frac);
        longint unsigned den;
        den = 255 * (longint'(1) << HUE_BITS);
        return 8'((v * (den - s * frac)) / den);
    endfunction

    // Predict the color of one pixel: returns {blue, green, red}
    function automatic logic [23:0] rgb_from_hsv(input logic [HUE_BITS-1:0] hue,
                                                 input logic [7:0] sat,
                                                 input logic [7:0] val);
        longint unsigned one;
        longint unsigned h6;
        longint unsigned frac;
        logic [2:0]      sector;
        logic [7:0]      p;
        logic [7:0]      q;
        logic [7:0]      t;
        one    = longint'(1) << HUE_BITS;
        h6     = longint'(hue) * 6;
        sector = 3'(h6 >> HUE_BITS);
        frac   = h6 & (one - 1);
        // Grey: every channel follows the value
        if (sat == 8'd0) begin
            return {val, val, val};
        end
        p = scaled_level(val, sat, one);
        q = scaled_level(val, sat, frac);
        t = scaled_level(val, sat, one - frac);
        case (sector)
            SECT_RED_YEL: return {p, t, val};
            SECT_YEL_GRN: return {p, val, q};
            SECT_GRN_CYN: return {t, val, p};
            SECT_CYN_BLU: return {val, q, p};
            SECT_BLU_MAG: return {val, p, t};
            default:      return {q, p, val};
        endcase
    endfunction

    // Mostly back to back or short, now and then long; none while steady
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Present one pixel word after a random gap; return once it is taken.
    // Hold tvalid high across back-to-back words so it is never toggled in one step.
    task automatic send_pixel(input logic [HUE_BITS-1:0] hue,
                              input logic [7:0] sat,
                              input logic [7:0] val);
        int unsigned gap;
        gap = pick_gap(src_steady);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({val, sat, hue});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if ($urandom_range(0, 149) == 0) begin
            src_steady = !src_steady;
        end
    endtask

    // Sink side: drop tready for random stretches, with steady runs in between
    initial begin : sink_stall
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 299) == 0) begin
                    sink_steady = !sink_steady;
                end
                stall_left = pick_gap(sink_steady);
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    // Record the expected color for every word accepted on the input
    always @(posedge i_clk) begin
        t_rgb_pending e;
        logic [23:0]  bgr;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            e.hue   = s_axis_tdata[HUE_BITS-1:0];
            e.sat   = s_axis_tdata[HUE_BITS +: 8];
            e.val   = s_axis_tdata[HUE_BITS+8 +: 8];
            bgr     = rgb_from_hsv(e.hue, e.sat, e.val);
            e.red   = bgr[7:0];
            e.green = bgr[15:8];
            e.blue  = bgr[23:16];
            rgb_pending_q.push_back(e);
        end
    end

    // Compare every word leaving the block with the oldest expectation
    always @(posedge i_clk) begin
        t_rgb_pending e;
        string        tag;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rgb_pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word 0x%06h", m_axis_tdata));
            end else begin
                e   = rgb_pending_q.pop_front();
                tag = $sformatf("h=%0d s=%0d v=%0d", e.hue, e.sat, e.val);
                if (m_axis_tdata[7:0] !== e.red) begin
                    report_mismatch($sformatf("%s red %0d, want %0d",
                                              tag, m_axis_tdata[7:0], e.red));
                end
                if (m_axis_tdata[15:8] !== e.green) begin
                    report_mismatch($sformatf("%s green %0d, want %0d",
                                              tag, m_axis_tdata[15:8], e.green));
                end
                if (m_axis_tdata[23:16] !== e.blue) begin
                    report_mismatch($sformatf("%s blue %0d, want %0d",
                                              tag, m_axis_tdata[23:16], e.blue));
                end
            end
        end
    end

    // Grey: zero saturation across hues and values
    task automatic test_grey();
        send_pixel(16'd0,     8'd0, 8'd0);
        send_pixel(16'd0,     8'd0, 8'd255);
        send_pixel(16'd21845, 8'd0, 8'd128);
        send_pixel(16'd65535, 8'd0, 8'd77);
        send_pixel(16'd40000, 8'd0, 8'd1);
    endtask

    // Field extremes: hue ends, full and minimal saturation and value
    task automatic test_extremes();
        send_pixel(16'd0,     8'd255, 8'd255);
        send_pixel(16'd65535, 8'd255, 8'd255);
        send_pixel(16'd65535, 8'd1,   8'd255);
        send_pixel(16'd0,     8'd255, 8'd0);
        send_pixel(16'd32768, 8'd1,   8'd1);
        send_pixel(16'hAAAA,  8'h55,  8'hAA);
        send_pixel(16'h5555,  8'hAA,  8'h55);
    endtask

    // Both sides of the five inner sector boundaries, so all six channel orders show up
    task automatic test_sector_edges();
        logic [HUE_BITS-1:0] edge_hue[10];
        edge_hue = '{16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
                     16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614};
        foreach (edge_hue[k]) begin
            send_pixel(edge_hue[k], 8'd200, 8'd250);
        end
        send_pixel(16'd5461, 8'd255, 8'd255);
    endtask

    // Random pixels; a share pin saturation or value to its ends
    task automatic test_random();
        logic [HUE_BITS-1:0] hue;
        logic [7:0]          sat;
        logic [7:0]          val;
        int unsigned         pick;
        repeat (RANDOM_WORDS) begin
            hue  = HUE_BITS'($urandom);
            sat  = 8'($urandom);
            val  = 8'($urandom);
            pick = $urandom_range(0, 19);
            case (pick)
                0: sat = 8'd0;
                1: sat = 8'd255;
                2: val = 8'd255;
                3: val = 8'd0;
                default: ;
            endcase
            send_pixel(hue, sat, val);
        end
    endtask

    initial begin : main_seq
        int unsigned waited;
        waited = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_grey();
        test_extremes();
        test_sector_edges();
        test_random();
        s_axis_tvalid <= 1'b0;

        // Drain the pipeline, then let the last stages settle
        while (rgb_pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rgb_pending_q.size() != 0) begin
            report_mismatch($sformatf("%0d words never came out", rgb_pending_q.size()));
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
